// ===== rtl/compacting_pair_set_table_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pair set table
// Shared property forms; every user has clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef COMPACTING_PAIR_SET_TABLE_TOP_ASSERT_SVH
`define COMPACTING_PAIR_SET_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define CPST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pair set table check failed");

// Next-cycle implication, checked outside reset
`define CPST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pair set table check failed");

`endif

// ===== rtl/cpst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpst_pkg
// Operation and status codes, and the controller command bundle.
// ----------------------------------------------------------------------------
package cpst_pkg;

  // Operation codes (code 3 decodes as a query)
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int KEY_W   = 16;
  localparam int COUNT_W = 6;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch request and run the parallel compare
    logic execute;  // apply the operation and load the result register
  } cpst_cmd_t;

endpackage

// ===== rtl/cpst_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpst_ctrl
// Two-state sequencer: takes a request, then executes it once the result
// register is free. Owns the input ready and the result valid.
// ----------------------------------------------------------------------------
`include "compacting_pair_set_table_top_assert.svh"

module cpst_ctrl
  import cpst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output cpst_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  // result register is empty or being drained this cycle
  assign out_free   = !out_valid_r || out_tready;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.execute = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid: set on execute, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // checks
  `CPST_ASSERT_NOW(a_cmd_excl, cmd.capture, !cmd.execute)
  `CPST_ASSERT_NEXT(a_exec_sets_valid, cmd.execute, out_valid_r)
  `CPST_ASSERT_NEXT(a_one_in_flight, cmd.capture, !in_tready)
  `CPST_ASSERT_NEXT(a_exec_waits, (state_r == S_EXEC) && !out_free, state_r == S_EXEC)

endmodule

// ===== rtl/cpst_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpst_datapath
// Slot registers with parallel compare, append at the count, one-step
// compaction on remove, and the result register.
// ----------------------------------------------------------------------------
`include "compacting_pair_set_table_top_assert.svh"

module cpst_datapath
  import cpst_pkg::*;
#(
  parameter int MAX_ENTRIES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cpst_cmd_t          cmd,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [KEY_W-1:0]   in_chapter_key,
  input  logic [KEY_W-1:0]   in_page_key,
  output logic               out_success,
  output logic [1:0]         out_status,
  output logic [COUNT_W-1:0] out_entry_count
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int PAIR_W = 2 * KEY_W;

  logic [PAIR_W-1:0]      table_r [MAX_ENTRIES];
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [MAX_ENTRIES-1:0] match_r;
  logic [PAIR_W-1:0]      key_r;
  logic [FUNC_W-1:0]      func_r;
  logic [PAIR_W-1:0]      in_key;

  logic                   present;
  logic                   full;
  logic [IDX_W-1:0]       first_idx;
  logic                   add_en;
  logic                   rem_en;
  logic                   success_nxt;
  logic [1:0]             status_nxt;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  logic                   success_r;
  logic [1:0]             status_r;
  logic [COUNT_W-1:0]     entry_count_r;

  assign in_key = {in_chapter_key, in_page_key};

  // request capture and compare against live slots
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_r  <= in_key;
      func_r <= in_func;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        match_r[i] <= (table_r[i] == in_key) && (CNT_W'(i) < count_r);
      end
    end
  end

  // first matching slot
  always_comb begin
    first_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  assign present = |match_r;
  assign full    = (count_r == CNT_W'(MAX_ENTRIES));

  // operation decode
  always_comb begin
    add_en      = 1'b0;
    rem_en      = 1'b0;
    success_nxt = present;
    status_nxt  = present ? ST_DONE : ST_ABSENT;
    count_nxt   = count_r;
    case (func_r)
      FUNC_ADD: begin
        success_nxt = 1'b0;
        if (present) begin
          status_nxt = ST_DUP;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          add_en      = cmd.execute;
          success_nxt = 1'b1;
          status_nxt  = ST_DONE;
          count_nxt   = count_r + 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (present) begin
          rem_en    = cmd.execute;
          count_nxt = count_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // slot update: append at count, or shift down from the removed slot
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (add_en && (count_r == CNT_W'(i))) begin
        table_r[i] <= key_r;
      end else if (rem_en && (IDX_W'(i) >= first_idx) && (i + 1 < MAX_ENTRIES)) begin
        table_r[i] <= table_r[(i + 1) % MAX_ENTRIES];
      end
    end
  end

  // count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
    end
  end

  // result register
  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      success_r     <= success_nxt;
      status_r      <= status_nxt;
      entry_count_r <= count_ext[COUNT_W-1:0];
    end
  end

  assign out_success     = success_r;
  assign out_status      = status_r;
  assign out_entry_count = entry_count_r;

  // checks
  `CPST_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_ENTRIES))
  `CPST_ASSERT_NEXT(a_remove_dec, rem_en, count_r == $past(count_r) - 1'b1)
  `CPST_ASSERT_NEXT(a_add_inc, add_en, count_r == $past(count_r) + 1'b1)
  `CPST_ASSERT_NOW(a_match_live, cmd.execute && present, CNT_W'(first_idx) < count_r)

endmodule

// ===== rtl/compacting_pair_set_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_pair_set_table_top
// Ordered set of (chapter, page) pairs with add, remove and query requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ stream: func selects add (0), remove (1) or
//   query (2, 3 behaves the same). Each request yields exactly one result
//   on the out_ stream: success, status and the pair count after the op.
//   Each request runs as a capture step that registers the key and
//   compares it against every slot at once, then an execute step that
//   applies the add or the one-step compaction and loads the result
//   register, which raises out_tvalid. in_tready is low from acceptance
//   until the execute step completes, so one request is in flight at a time.
//   A finished result sits in its own register, so the next request is
//   taken while the receiver stalls; that request then waits in the
//   execute step until the result register drains.
//   Reset clears the count and all handshake state; slot contents are
//   not cleared and are never read above the count.
// ----------------------------------------------------------------------------
module compacting_pair_set_table_top
  import cpst_pkg::*;
#(
  parameter int MAX_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // [1:0] func, [17:2] chapter_key, [33:18] page_key
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata    // [0] success, [2:1] status, [8:3] entry_count
);

  cpst_cmd_t          cmd;
  logic               success;
  logic [1:0]         status;
  logic [COUNT_W-1:0] entry_count;

  cpst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  cpst_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_func         (in_tdata[1:0]),
    .in_chapter_key  (in_tdata[17:2]),
    .in_page_key     (in_tdata[33:18]),
    .out_success     (success),
    .out_status      (status),
    .out_entry_count (entry_count)
  );

  assign out_tdata = {7'd0, entry_count, status, success};

endmodule
